// ===== rtl/slpg_pkg.sv =====
// ---------------------------------------------------------------------------
// slpg_pkg: shared definitions for the sample loop position generator
// Field widths, register indexes, loop mode and operation codes.
// ---------------------------------------------------------------------------
package slpg_pkg;

    // default fixed-point geometry of the play position
    localparam int INDEX_BITS_DEF    = 24;
    localparam int FRACTION_BITS_DEF = 16;

    // fixed field widths
    localparam int FRAME_COUNT_W = 25;
    localparam int PHASE_STEP_W  = 24;
    localparam int LOOP_MODE_W   = 2;
    localparam int SEEK_OFFSET_W = 25;
    localparam int FRAME_INDEX_W = 24;

    // stream packing
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 32;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 25;

    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_COUNT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PHASE_STEP  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_LOOP_MODE   = 2'd2;

    // register reset values
    localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RST = 25'd1;
    localparam logic [PHASE_STEP_W-1:0]  PHASE_STEP_RST  = 24'd65536;

    // loop modes
    localparam logic [LOOP_MODE_W-1:0] MODE_ONE_SHOT  = 2'd0;
    localparam logic [LOOP_MODE_W-1:0] MODE_FORWARD   = 2'd1;
    localparam logic [LOOP_MODE_W-1:0] MODE_BACKWARD  = 2'd2;
    localparam logic [LOOP_MODE_W-1:0] MODE_PING_PONG = 2'd3;

    // beat operations
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SEEK = 1'b1;

endpackage

// ===== rtl/sample_loop_position_generator.sv =====
// ---------------------------------------------------------------------------
// sample_loop_position_generator
// Fixed-point playback position for a sample buffer with one-shot, forward,
// backward and ping-pong looping, plus seek; one result beat per input beat.
// ---------------------------------------------------------------------------
// Result beat is registered: valid on the master side the cycle after input acceptance.
// Throughput: 1 beat per cycle unless the master stalls; one add, bound compare
//   and clamp run combinationally from the state registers to the result
//   register. A full output register refills in the same cycle the master drains it.
// Reset (i_rst_n low, synchronous): position 0, forward, playing; registers go
//   to frame_count 1, phase_step 1.0, one-shot; output register empties.
module sample_loop_position_generator
    import slpg_pkg::*;
#(
    parameter int INDEX_BITS    = INDEX_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // slave side
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,  // [24:0] seek_offset, [31:25] zero
    input  logic [S_TUSER_W-1:0]  i_s_axis_tuser,  // [0] operation
    // master side
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata   // [23:0] frame_index, [24] playing,
                                                   // [25] moving_backward,
                                                   // [26] seek_ignored, [31:27] zero
);

    // position: two's complement, INDEX_BITS+2 integer and FRACTION_BITS fraction bits
    localparam int POS_W = INDEX_BITS + 2 + FRACTION_BITS;
    // effective count lies in [1, 2^INDEX_BITS]
    localparam int CNT_W = INDEX_BITS + 1;
    // common width for comparing register/offset values against the count
    localparam int CMP_W = (CNT_W > FRAME_COUNT_W) ? CNT_W : FRAME_COUNT_W;
    // width holding both the internal index and the output field
    localparam int IDX_W = (CNT_W > FRAME_INDEX_W) ? CNT_W : FRAME_INDEX_W;

    // configuration registers
    logic [FRAME_COUNT_W-1:0] r_frame_count;
    logic [PHASE_STEP_W-1:0]  r_phase_step;
    logic [LOOP_MODE_W-1:0]   r_loop_mode;

    // play state
    logic signed [POS_W-1:0] r_pos, n_pos;
    logic                    r_reverse, n_reverse;
    logic                    r_stopped, n_stopped;

    // output register
    logic                     r_out_valid;
    logic [FRAME_INDEX_W-1:0] r_out_index, n_out_index;
    logic                     r_out_playing;
    logic                     r_out_backward, n_out_backward;
    logic                     r_out_ignored, n_out_ignored;

    logic s_acc;
    logic op;
    logic [SEEK_OFFSET_W-1:0] seek_offset;

    logic [CMP_W-1:0] fc_ext, lim_ext, off_ext, cnt_ext;
    logic [CNT_W-1:0] count;
    logic signed [POS_W-1:0] bound, step, seek_pos;
    logic [CNT_W-1:0] idx_raw;
    logic [IDX_W-1:0] idx_ext;

    // output register frees up when empty or drained this cycle
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;

    assign op          = i_s_axis_tuser[0];
    assign seek_offset = i_s_axis_tdata[SEEK_OFFSET_W-1:0];

    // effective count: frame_count limited to [1, 2^INDEX_BITS]
    assign fc_ext  = CMP_W'(r_frame_count);
    assign lim_ext = CMP_W'(1) << INDEX_BITS;
    always_comb begin
        if (fc_ext == '0) begin
            cnt_ext = CMP_W'(1);
        end else if (fc_ext > lim_ext) begin
            cnt_ext = lim_ext;
        end else begin
            cnt_ext = fc_ext;
        end
    end
    assign count = cnt_ext[CNT_W-1:0];

    assign bound    = POS_W'(count) <<< FRACTION_BITS;
    assign step     = POS_W'(r_phase_step);
    assign off_ext  = CMP_W'(seek_offset);
    // only used when the offset is within the count, so it fits
    assign seek_pos = POS_W'(seek_offset) <<< FRACTION_BITS;

    // next state
    always_comb begin
        n_pos         = r_pos;
        n_reverse     = r_reverse;
        n_stopped     = r_stopped;
        n_out_ignored = 1'b0;
        if (op == OP_SEEK) begin
            if (off_ext > cnt_ext) begin
                n_out_ignored = 1'b1;
            end else begin
                n_pos = seek_pos;
            end
        end else if (!r_stopped) begin
            case (r_loop_mode)
                MODE_ONE_SHOT: begin
                    if (r_pos < bound) n_pos = r_pos + step;
                    else               n_stopped = 1'b1;
                end
                MODE_FORWARD: begin
                    if (r_pos < bound) n_pos = r_pos + step;
                    else               n_pos = r_pos - bound;
                end
                MODE_BACKWARD: begin
                    if (r_pos > 0) n_pos = r_pos - step;
                    else           n_pos = r_pos + bound;
                end
                default: begin
                    // ping-pong: hold one tick at either end while turning around
                    if (!r_reverse) begin
                        if (r_pos < bound) n_pos = r_pos + step;
                        else               n_reverse = 1'b1;
                    end else begin
                        if (r_pos > 0) n_pos = r_pos - step;
                        else           n_reverse = 1'b0;
                    end
                end
            endcase
        end
    end

    // frame to read from the updated position, clamped into the buffer
    always_comb begin
        idx_raw = n_pos[FRACTION_BITS +: CNT_W];
        if (n_pos < 0) begin
            idx_raw = '0;
        end else if (idx_raw >= count) begin
            idx_raw = count - CNT_W'(1);
        end
    end
    assign idx_ext     = IDX_W'(idx_raw);
    assign n_out_index = idx_ext[FRAME_INDEX_W-1:0];

    assign n_out_backward = (r_loop_mode == MODE_BACKWARD) ||
                            ((r_loop_mode == MODE_PING_PONG) && n_reverse);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= FRAME_COUNT_RST;
            r_phase_step  <= PHASE_STEP_RST;
            r_loop_mode   <= MODE_ONE_SHOT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_FRAME_COUNT: r_frame_count <= i_cfg_wdata[FRAME_COUNT_W-1:0];
                CFG_PHASE_STEP:  r_phase_step  <= i_cfg_wdata[PHASE_STEP_W-1:0];
                CFG_LOOP_MODE:   r_loop_mode   <= i_cfg_wdata[LOOP_MODE_W-1:0];
                default: ;  // unused index: write dropped
            endcase
        end
    end

    // play state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_reverse   <= 1'b0;
            r_stopped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_acc) begin
                r_pos     <= n_pos;
                r_reverse <= n_reverse;
                r_stopped <= n_stopped;
            end
            if (s_acc) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_out_index    <= n_out_index;
            r_out_playing  <= !n_stopped;
            r_out_backward <= n_out_backward;
            r_out_ignored  <= n_out_ignored;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(M_TDATA_W - FRAME_INDEX_W - 3)'(0), r_out_ignored,
                              r_out_backward, r_out_playing, r_out_index};

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------
    // a finished one-shot stays finished until reset
    a_stopped_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |=> r_stopped)
        else $error("stopped flag cleared without reset");

    // a tick on a stopped block leaves the position alone
    a_stopped_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && (op == OP_TICK) && r_stopped) |=> $stable(r_pos))
        else $error("position moved while stopped");

    // every accepted beat lands in the output register
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> r_out_valid)
        else $error("accepted beat produced no result");

    // seek_ignored is only ever reported for seeks
    a_ignore_only_seek: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && (op == OP_TICK)) |=> !r_out_ignored)
        else $error("seek_ignored set on a tick");

    // the slave side never stalls while the output register is empty
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_s_axis_tready)
        else $error("stall with empty output register");

endmodule

// ===== tb/sample_loop_position_generator_tb.sv =====
// ---------------------------------------------------------------------------
// sample_loop_position_generator_tb
// Self-checking bench for the loop position generator. Drives tick and seek
// beats over the slave stream, models the position/direction/stop state per
// beat and compares every master beat field by field against that model.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sample_loop_position_generator_tb;
    import slpg_pkg::*;

    // 2 sign/headroom bits above the frame index, then the fraction
    localparam int POS_W = INDEX_BITS_DEF + 2 + FRACTION_BITS_DEF;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNMAPPED = 2'd3;
    localparam logic [FRAME_COUNT_W-1:0] COUNT_LIMIT = 25'd1 << INDEX_BITS_DEF;
    localparam logic [FRAME_COUNT_W-1:0] COUNT_ALL_ONES = '1;
    localparam logic [PHASE_STEP_W-1:0] STEP_UNITY = 24'd1 << FRACTION_BITS_DEF;
    localparam logic [PHASE_STEP_W-1:0] STEP_MAX = '1;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        logic                     seek_ignored;
        logic                     moving_backward;
        logic                     playing;
        logic [FRAME_INDEX_W-1:0] frame_index;
    } t_frame_result;

    // -----------------------------------------------------------------------
    // Position model plus queue of expected master beats
    // -----------------------------------------------------------------------
    class t_position_scoreboard;
        logic [FRAME_COUNT_W-1:0] frame_count;
        logic [PHASE_STEP_W-1:0]  phase_step;
        logic [LOOP_MODE_W-1:0]   loop_mode;
        logic signed [POS_W-1:0]  position;
        bit                       reverse;
        bit                       stopped;
        t_frame_result            expected_q[$];
        int                       errors;
        int                       checked;

        function new();
            frame_count = FRAME_COUNT_RST;
            phase_step  = PHASE_STEP_RST;
            loop_mode   = MODE_ONE_SHOT;
            position    = '0;
            reverse     = 0;
            stopped     = 0;
            errors      = 0;
            checked     = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_FRAME_COUNT: frame_count = val[FRAME_COUNT_W-1:0];
                CFG_PHASE_STEP:  phase_step  = val[PHASE_STEP_W-1:0];
                CFG_LOOP_MODE:   loop_mode   = val[LOOP_MODE_W-1:0];
                default: ;  // unmapped index: dropped
            endcase
        endfunction

        // frame count clamped to [1, 2^INDEX_BITS]
        function logic [FRAME_COUNT_W-1:0] eff_count();
            if (frame_count == '0) return FRAME_COUNT_W'(1);
            if (frame_count > COUNT_LIMIT) return COUNT_LIMIT;
            return frame_count;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_input(logic op, logic [SEEK_OFFSET_W-1:0] offset);
            logic [FRAME_COUNT_W-1:0] cnt;
            logic signed [POS_W-1:0]  bound;
            logic signed [POS_W-1:0]  step;
            logic [FRAME_COUNT_W-1:0] idx;
            t_frame_result            res;
            cnt   = eff_count();
            bound = $signed({1'b0, cnt, {FRACTION_BITS_DEF{1'b0}}});
            step  = $signed({{(POS_W-PHASE_STEP_W){1'b0}}, phase_step});
            res   = '0;
            if (op == OP_SEEK) begin
                if (offset > cnt) res.seek_ignored = 1'b1;
                else position = $signed({1'b0, offset, {FRACTION_BITS_DEF{1'b0}}});
            end else if (!stopped) begin
                case (loop_mode)
                    MODE_ONE_SHOT: begin
                        if (position < bound) position += step;
                        else stopped = 1;
                    end
                    MODE_FORWARD: begin
                        if (position < bound) position += step;
                        else position -= bound;
                    end
                    MODE_BACKWARD: begin
                        if (position > 0) position -= step;
                        else position += bound;
                    end
                    default: begin
                        if (!reverse) begin
                            if (position < bound) position += step;
                            else reverse = 1;
                        end else begin
                            if (position > 0) position -= step;
                            else reverse = 0;
                        end
                    end
                endcase
            end
            // negative reads frame 0, past the end reads the last frame
            if (position[POS_W-1]) begin
                idx = '0;
            end else begin
                idx = position[POS_W-2:FRACTION_BITS_DEF];
                if (idx >= cnt) idx = cnt - FRAME_COUNT_W'(1);
            end
            res.frame_index     = idx[FRAME_INDEX_W-1:0];
            res.playing         = !stopped;
            res.moving_backward = (loop_mode == MODE_BACKWARD) ||
                                  (loop_mode == MODE_PING_PONG && reverse);
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data);
            t_frame_result exp_res;
            t_frame_result got;
            got = data[$bits(t_frame_result)-1:0];
            if (expected_q.size() == 0) begin
                $error("result beat 0x%08h arrived with nothing expected", data);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            checked++;
            if (got.frame_index !== exp_res.frame_index) begin
                $error("frame_index: expected %0d, got %0d", exp_res.frame_index,
                       got.frame_index);
                errors++;
            end
            if (got.playing !== exp_res.playing) begin
                $error("playing: expected %0b, got %0b", exp_res.playing, got.playing);
                errors++;
            end
            if (got.moving_backward !== exp_res.moving_backward) begin
                $error("moving_backward: expected %0b, got %0b", exp_res.moving_backward,
                       got.moving_backward);
                errors++;
            end
            if (got.seek_ignored !== exp_res.seek_ignored) begin
                $error("seek_ignored: expected %0b, got %0b", exp_res.seek_ignored,
                       got.seek_ignored);
                errors++;
            end
            if (data[M_TDATA_W-1:$bits(t_frame_result)] !== '0) begin
                $error("tdata padding: expected 0, got 0x%0h",
                       data[M_TDATA_W-1:$bits(t_frame_result)]);
                errors++;
            end
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // DUT hookup
    // -----------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [S_TDATA_W-1:0]  i_s_axis_tdata;   // [24:0] seek_offset, [31:25] zero
    logic [S_TUSER_W-1:0]  i_s_axis_tuser;   // [0] operation
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [M_TDATA_W-1:0]  o_m_axis_tdata;   // [23:0] frame_index, [24] playing,
                                             // [25] moving_backward,
                                             // [26] seek_ignored, [31:27] zero

    sample_loop_position_generator DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    t_position_scoreboard sb = new();

    // bench state shared between processes
    bit calm;            // no random gaps or stalls on either side while set
    bit hold_request;    // asks the receiver for one long hold-off
    int hold_left;
    int stall_left;
    int beats_sent;
    int cfg_writes;
    int holds_done;

    // 10 ns clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Monitor: everything sampled on the rising edge. Result check goes first;
    // a result can never belong to the beat taken on the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) sb.check_result(o_m_axis_tdata);
            if (i_s_axis_tvalid && o_s_axis_tready)
                sb.note_input(i_s_axis_tuser[0], i_s_axis_tdata[SEEK_OFFSET_W-1:0]);
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Receiver: own process, changes tready on the falling edge
    initial begin
        i_m_axis_tready = 1'b0;
        hold_left  = 0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 0;
                holds_done++;
            end
            if (hold_left > 0) begin
                i_m_axis_tready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                i_m_axis_tready = 1'b0;
                stall_left--;
            end else if (!calm && $urandom_range(0, 99) < 25) begin
                i_m_axis_tready = 1'b0;
                stall_left = pick_gap();
            end else begin
                i_m_axis_tready = 1'b1;
            end
        end
    end

    // one beat on the slave side; starts and ends on a falling edge
    task automatic send_beat(logic op, logic [SEEK_OFFSET_W-1:0] offset);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = op;
        i_s_axis_tdata  = {{(S_TDATA_W-SEEK_OFFSET_W){1'b0}}, offset};
        do @(posedge i_clk); while (!o_s_axis_tready);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic tick();
        send_beat(OP_TICK, SEEK_OFFSET_W'($urandom_range(0, 2**SEEK_OFFSET_W - 1)));
    endtask

    task automatic seek(logic [SEEK_OFFSET_W-1:0] offset);
        send_beat(OP_SEEK, offset);
    endtask

    // register write; only called with the stream idle
    task automatic cfg_write(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_s_axis_tvalid = 1'b0;
        i_cfg_we    = 1'b1;
        i_cfg_addr  = idx;
        i_cfg_wdata = val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // sender pauses until every result is back
    task automatic wait_idle();
        i_s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    function automatic logic [FRAME_COUNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return FRAME_COUNT_W'($urandom_range(1, 12));
        if (r < 68) return '0;
        if (r < 74) return COUNT_ALL_ONES;
        if (r < 80) return COUNT_LIMIT;
        return FRAME_COUNT_W'($urandom_range(13, 2**FRAME_COUNT_W - 1));
    endfunction

    function automatic logic [PHASE_STEP_W-1:0] pick_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return PHASE_STEP_W'($urandom_range(1, 3 * STEP_UNITY));
        // quarter-frame multiples
        if (r < 60) return PHASE_STEP_W'(24'h4000 * $urandom_range(1, 16));
        if (r < 70) return '0;
        if (r < 80) return STEP_MAX;
        return PHASE_STEP_W'($urandom_range(0, 2**PHASE_STEP_W - 1));
    endfunction

    // seek targets: mostly around the buffer, some near its end, some anywhere
    function automatic logic [SEEK_OFFSET_W-1:0] pick_offset();
        logic [FRAME_COUNT_W-1:0] cnt;
        int r;
        cnt = sb.eff_count();
        r = $urandom_range(0, 99);
        if (r < 45) return SEEK_OFFSET_W'($urandom_range(0, (cnt > 14) ? 16 : cnt + 2));
        if (r < 70)
            return SEEK_OFFSET_W'(cnt + 1 - $urandom_range(0, (cnt > 3) ? 4 : cnt + 1));
        if (r < 80) return ($urandom_range(0, 1) != 0) ? COUNT_LIMIT : '0;
        return SEEK_OFFSET_W'($urandom_range(0, 2**SEEK_OFFSET_W - 1));
    endfunction

    task automatic random_beats(int n, int seek_pct);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < seek_pct) seek(pick_offset());
            else tick();
        end
    endtask

    task automatic new_setting(logic [LOOP_MODE_W-1:0] mode);
        cfg_write(CFG_FRAME_COUNT, pick_count());
        cfg_write(CFG_PHASE_STEP, CFG_DATA_W'(pick_step()));
        cfg_write(CFG_LOOP_MODE, CFG_DATA_W'(mode));
    endtask

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_addr      = '0;
        i_cfg_wdata     = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = OP_TICK;
        calm            = 1;
        hold_request    = 0;
        beats_sent      = 0;
        cfg_writes      = 0;
        holds_done      = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // --- directed: reset setting is one-shot over a single frame, so only
        // one tick here; a second would stop playback for the whole run
        seek('0);
        seek(25'd1);                 // seek to exactly the count: taken
        seek(25'd2);                 // one past the count: refused
        seek(COUNT_ALL_ONES);
        seek('0);
        tick();
        wait_idle();

        // zero frame count acts as one frame; largest step
        cfg_write(CFG_FRAME_COUNT, '0);
        cfg_write(CFG_PHASE_STEP, CFG_DATA_W'(STEP_MAX));
        cfg_write(CFG_LOOP_MODE, CFG_DATA_W'(MODE_FORWARD));
        cfg_write(CFG_UNMAPPED, COUNT_ALL_ONES);   // must be dropped
        repeat (3) tick();
        wait_idle();

        // oversize count clamps to 2^INDEX_BITS; zero step backward
        cfg_write(CFG_FRAME_COUNT, COUNT_ALL_ONES);
        cfg_write(CFG_PHASE_STEP, '0);
        cfg_write(CFG_LOOP_MODE, CFG_DATA_W'(MODE_BACKWARD));
        seek(COUNT_LIMIT);           // lands past the end, index clamps
        tick();
        seek('0);
        repeat (2) tick();           // at zero: wraps up by the full bound
        wait_idle();

        // backward step of 1.5 drives the position negative
        cfg_write(CFG_FRAME_COUNT, 25'd3);
        cfg_write(CFG_PHASE_STEP, 25'h18000);
        seek(25'd1);
        repeat (2) tick();
        seek(25'd4);
        seek(25'd3);
        wait_idle();

        // ping-pong over two frames, both turnarounds
        cfg_write(CFG_FRAME_COUNT, 25'd2);
        cfg_write(CFG_PHASE_STEP, 25'h0C000);
        cfg_write(CFG_LOOP_MODE, CFG_DATA_W'(MODE_PING_PONG));
        seek('0);
        repeat (8) tick();
        wait_idle();

        // --- random phases over forward, backward and ping-pong
        for (int p = 0; beats_sent < 1150; p++) begin
            new_setting(LOOP_MODE_W'($urandom_range(MODE_FORWARD, MODE_PING_PONG)));
            calm = (p % 5 == 4);
            if (p == 3) begin
                // receiver blocks for a long stretch while beats keep coming
                calm = 1;
                hold_request = 1;
                random_beats(HOLD_CYCLES + 20, 20);
            end else begin
                random_beats($urandom_range(40, 120), 20);
            end
            calm = 0;
            wait_idle();
        end

        // --- one-shot runs off the end; the stop sticks for the rest of the run
        cfg_write(CFG_FRAME_COUNT, CFG_DATA_W'($urandom_range(2, 6)));
        cfg_write(CFG_PHASE_STEP, CFG_DATA_W'($urandom_range(24'h8000, 24'h20000)));
        cfg_write(CFG_LOOP_MODE, CFG_DATA_W'(MODE_ONE_SHOT));
        seek('0);
        random_beats(80, 5);
        wait_idle();
        new_setting(MODE_PING_PONG);
        random_beats(40, 30);
        wait_idle();
        new_setting(MODE_BACKWARD);
        random_beats(40, 30);
        wait_idle();

        repeat (5) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors += sb.pending();
        end
        $display("Coverage: %0d beats in, %0d results checked, %0d register writes,",
                 beats_sent, sb.checked, cfg_writes);
        $display("  %0d long receiver hold(s), one-shot stop %s.", holds_done,
                 sb.stopped ? "reached" : "not reached");
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
